// ----- src/assert_macros.svh -----
// assertion macros used by the rate meter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checked at every rising clock edge
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

// ----- src/tmr_pkg.sv -----
// types and constants of the transfer rate meter
`timescale 1ns / 1ps
package tmr_pkg;

  localparam int unsigned HistoryDepthDef = 16;
  localparam int unsigned TimeW  = 40;
  localparam int unsigned BytesW = 48;
  localparam int unsigned PctW   = 17;
  localparam int unsigned SumW   = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned NumW   = 50;
  localparam int unsigned KW     = 20;

  localparam logic [KW-1:0]     UsecPerSec = 20'd1000000;
  localparam logic [KW-1:0]     PctScale   = 20'd100;
  localparam logic [PctW-1:0]   PctCap     = 17'd100000;
  localparam logic [PctW:0]     RampTop    = 18'd199;
  localparam logic [PctW:0]     RampStep   = 18'd2;
  localparam logic [BytesW-1:0] Max48      = {BytesW{1'b1}};
  localparam logic [SumW-1:0]   Max64      = {SumW{1'b1}};
  localparam logic [CountW-1:0] MaxCount   = {CountW{1'b1}};

  typedef enum logic [2:0] {
    CFG_MIN_INTERVAL  = 3'd0,
    CFG_HIST_INTERVAL = 3'd1,
    CFG_COUNT_BITS    = 3'd2,
    CFG_EXPECTED      = 3'd3,
    CFG_START_OFFSET  = 3'd4,
    CFG_HIST_LEN      = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    DIV_RATE = 1'b0,
    DIV_PCT  = 1'b1
  } div_mode_e;

  typedef struct packed {
    logic              start;
    div_mode_e         mode;
    logic [NumW-1:0]   num;
    logic [BytesW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BytesW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ring_ctl_t;

endpackage

// ----- src/tmr_if.sv -----
// valid/ready channels of the rate meter
`timescale 1ns / 1ps
interface tmr_in_if import tmr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  elapsed_time;
  logic [BytesW-1:0] total_bytes;
  logic              total_known;
  logic              final_update;

  modport source (output valid, elapsed_time, total_bytes, total_known, final_update,
                  input ready);
  modport sink (input valid, elapsed_time, total_bytes, total_known, final_update,
                output ready);
endinterface

interface tmr_out_if import tmr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BytesW-1:0] current_rate;
  logic [BytesW-1:0] window_rate;
  logic [PctW-1:0]   percent_done;
  logic [BytesW-1:0] lowest_rate;
  logic [BytesW-1:0] highest_rate;
  logic [SumW-1:0]   rate_total;
  logic [SumW-1:0]   rate_square_total;
  logic [CountW-1:0] sample_count;

  modport source (output valid, current_rate, window_rate, percent_done, lowest_rate,
                  highest_rate, rate_total, rate_square_total, sample_count,
                  input ready);
  modport sink (input valid, current_rate, window_rate, percent_done, lowest_rate,
                highest_rate, rate_total, rate_square_total, sample_count,
                output ready);
endinterface

// ----- src/transfer_rate_meter.sv -----
// top level of the transfer rate meter: sequencer, statistics and configuration
//
// in_i carries one update per transfer: elapsed time in microseconds, the byte
// total so far, a flag that the total is valid and a flag for the last update.
// out_o gives one result per update: current and windowed rate, percentage or
// ramp, min/max, the saturating sums of rates and squared rates and the count.
// cfg_we_i/cfg_idx_i/cfg_data_i write the six settings, only while idle; the
// user must keep to this, the block does not enforce it. Updates are handled
// one at a time. Up to four divisions can be needed per update: the new rate,
// the window average, the final average and the percentage each run through
// the shared divider (a scaling multiply and add, then 70 quotient bits, one
// per cycle). Index wrap in the history ring is done by repeated subtraction
// of the ring length.
// Reset clears all statistics and the valid bits of the ring at once; no
// clearing pass is needed. A finished result sits in the output register; if
// the receiver stalls, the next update is accepted and worked on but its
// result waits until the previous one has been taken.
`timescale 1ns / 1ps
module transfer_rate_meter import tmr_pkg::*; #(
  parameter int unsigned HistoryDepth = HistoryDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tmr_in_if.sink          in_i,
  tmr_out_if.source       out_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [47:0]     cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned IW = $clog2(HistoryDepth);
  localparam int unsigned LW = $clog2(HistoryDepth + 1);
  localparam int unsigned CW = (LW > 5) ? LW : 5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_RATE_WAIT, ST_SQ0, ST_SQ1, ST_SQ2, ST_STAT,
    ST_RING_RD, ST_RING_CHK, ST_MOD_T, ST_MOD_H, ST_WRITE, ST_WIN_RD,
    ST_WIN_WAIT, ST_FINAL, ST_FIN_WAIT, ST_PCT, ST_PCT_WAIT, ST_OUT
  } state_e;

  // configuration
  logic [19:0]       min_int_q;
  logic [31:0]       hist_int_q;
  logic              count_bits_q;
  logic [BytesW-1:0] expected_q;
  logic [BytesW-1:0] offset_q;
  logic [4:0]        hist_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q    <= 20'd10000;
      hist_int_q   <= 32'd1000000;
      count_bits_q <= 1'b0;
      expected_q   <= '0;
      offset_q     <= '0;
      hist_len_q   <= 5'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_INTERVAL:  min_int_q    <= cfg_data_i[19:0];
        CFG_HIST_INTERVAL: hist_int_q   <= cfg_data_i[31:0];
        CFG_COUNT_BITS:    count_bits_q <= cfg_data_i[0];
        CFG_EXPECTED:      expected_q   <= cfg_data_i;
        CFG_START_OFFSET:  offset_q     <= cfg_data_i;
        CFG_HIST_LEN:      hist_len_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  state_e            state_q;
  logic [TimeW-1:0]  now_q;
  logic [BytesW-1:0] tot_q;
  logic              known_q, fin_q;
  logic [BytesW-1:0] prev_tot_q, pend_q, prev_rate_q, rate_q, meas_q, win_q, avg_q;
  logic [TimeW-1:0]  prev_time_q;
  logic [BytesW-1:0] min_q, max_q;
  logic [SumW-1:0]   sum_q, sq_q;
  logic [CountW-1:0] count_q;
  logic [PctW-1:0]   pct_q;
  logic [95:0]       acc_q;
  logic [IW-1:0]     head_q, tail_q, last_q;
  logic [LW-1:0]     m_q;
  logic              out_v_q;
  logic [BytesW-1:0] o_cur_q, o_win_q, o_min_q, o_max_q;
  logic [PctW-1:0]   o_pct_q;
  logic [SumW-1:0]   o_sum_q, o_sq_q;
  logic [CountW-1:0] o_cnt_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  ring_ctl_t         ring_ctl;
  logic [IW-1:0]     ring_raddr;
  logic [TimeW-1:0]  ring_rt;
  logic [BytesW-1:0] ring_rb;

  // effective ring length
  logic [CW-1:0] hl_c, dep_c, len_c;
  logic [LW-1:0] len_eff;
  assign hl_c    = CW'(hist_len_q);
  assign dep_c   = CW'(HistoryDepth);
  assign len_c   = (hl_c == '0) ? CW'(1) : ((hl_c > dep_c) ? dep_c : hl_c);
  assign len_eff = LW'(len_c);

  logic [BytesW-1:0] delta;
  logic              hold;
  logic [BytesW:0]   pend_sum;
  logic [BytesW-1:0] meas_new;
  logic [23:0]       mul_a, mul_b;
  logic [47:0]       mul_p;
  logic [SumW:0]     sum_add, sq_add;
  logic [PctW:0]     ramp;
  logic              out_load;

  assign delta    = (known_q && (tot_q > prev_tot_q)) ? tot_q - prev_tot_q : '0;
  assign hold     = {1'b0, now_q} <= ({1'b0, prev_time_q} + (TimeW+1)'(min_int_q));
  assign pend_sum = {1'b0, pend_q} + {1'b0, delta};
  assign meas_new = !count_bits_q ? div_rsp.quot :
                    ((|div_rsp.quot[47:45]) ? Max48 : {div_rsp.quot[44:0], 3'b000});
  assign mul_a    = (state_q == ST_SQ2) ? meas_q[47:24] : meas_q[23:0];
  assign mul_b    = (state_q == ST_SQ0) ? meas_q[23:0] : meas_q[47:24];
  assign mul_p    = mul_a * mul_b;
  assign sum_add  = {1'b0, sum_q} + (SumW+1)'(meas_q);
  assign sq_add   = {1'b0, sq_q} + {1'b0, acc_q[63:0]};
  assign ramp     = {1'b0, pct_q} + ((rate_q != '0) ? RampStep : '0);
  assign out_load = (state_q == ST_OUT) && (!out_v_q || out_o.ready);

  assign in_i.ready = (state_q == ST_IDLE);

  // divider requests and ring accesses
  always_comb begin
    div_req.start = 1'b0;
    div_req.mode  = DIV_RATE;
    div_req.num   = '0;
    div_req.den   = '0;
    ring_ctl.rd   = 1'b0;
    ring_ctl.wr   = 1'b0;
    ring_raddr    = tail_q;
    case (state_q)
      ST_PREP: begin
        div_req.start = !hold;
        div_req.num   = NumW'(delta) + NumW'(pend_q);
        div_req.den   = BytesW'(now_q - prev_time_q);
      end
      ST_RING_RD: ring_ctl.rd = 1'b1;
      ST_WRITE: begin
        ring_ctl.wr = 1'b1;
        ring_ctl.rd = (head_q != last_q);
        ring_raddr  = head_q;
      end
      ST_WIN_RD: begin
        div_req.start = now_q > ring_rt;
        div_req.num   = (tot_q > ring_rb) ? NumW'(tot_q - ring_rb) : '0;
        div_req.den   = BytesW'(now_q - ring_rt);
      end
      ST_FINAL: begin
        div_req.start = fin_q;
        div_req.num   = (tot_q > offset_q) ? NumW'(tot_q - offset_q) : '0;
        div_req.den   = (now_q == '0) ? BytesW'(1) : BytesW'(now_q);
      end
      ST_PCT: begin
        div_req.start = (expected_q != '0);
        div_req.mode  = DIV_PCT;
        div_req.num   = NumW'(tot_q);
        div_req.den   = expected_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      tot_q       <= '0;
      known_q     <= 1'b0;
      fin_q       <= 1'b0;
      prev_tot_q  <= '0;
      prev_time_q <= '0;
      pend_q      <= '0;
      prev_rate_q <= '0;
      rate_q      <= '0;
      meas_q      <= '0;
      win_q       <= '0;
      avg_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      count_q     <= '0;
      pct_q       <= '0;
      acc_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      last_q      <= '0;
      m_q         <= '0;
      out_v_q     <= 1'b0;
      o_cur_q     <= '0;
      o_win_q     <= '0;
      o_pct_q     <= '0;
      o_min_q     <= '0;
      o_max_q     <= '0;
      o_sum_q     <= '0;
      o_sq_q      <= '0;
      o_cnt_q     <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            now_q   <= in_i.elapsed_time;
            tot_q   <= in_i.total_bytes;
            known_q <= in_i.total_known;
            fin_q   <= in_i.final_update;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (known_q) begin
            prev_tot_q <= tot_q;
          end
          if (hold) begin
            pend_q      <= pend_sum[BytesW] ? Max48 : pend_sum[BytesW-1:0];
            rate_q      <= prev_rate_q;
            state_q     <= ST_RING_RD;
          end else begin
            state_q <= ST_RATE_WAIT;
          end
        end
        ST_RATE_WAIT: begin
          if (div_rsp.done) begin
            rate_q      <= div_rsp.quot;
            prev_rate_q <= div_rsp.quot;
            prev_time_q <= now_q;
            pend_q      <= '0;
            meas_q      <= meas_new;
            state_q     <= ST_SQ0;
          end
        end
        ST_SQ0: begin
          acc_q   <= 96'(mul_p);
          state_q <= ST_SQ1;
        end
        ST_SQ1: begin
          acc_q   <= acc_q + {23'd0, mul_p, 25'd0};
          state_q <= ST_SQ2;
        end
        ST_SQ2: begin
          acc_q   <= acc_q + {mul_p, 48'd0};
          state_q <= ST_STAT;
        end
        ST_STAT: begin
          if ((count_q == '0) || (meas_q < min_q)) begin
            min_q <= meas_q;
          end
          if (meas_q > max_q) begin
            max_q <= meas_q;
          end
          sum_q <= sum_add[SumW] ? Max64 : sum_add[SumW-1:0];
          if ((|acc_q[95:64]) || sq_add[SumW]) begin
            sq_q <= Max64;
          end else begin
            sq_q <= sq_add[SumW-1:0];
          end
          if (count_q != MaxCount) begin
            count_q <= count_q + 1'b1;
          end
          state_q <= ST_RING_RD;
        end
        ST_RING_RD: state_q <= ST_RING_CHK;
        ST_RING_CHK: begin
          if ((ring_rt != '0) &&
              ({1'b0, now_q} < ({1'b0, ring_rt} + (TimeW+1)'(hist_int_q)))) begin
            state_q <= ST_FINAL;
          end else if (ring_rt != '0) begin
            m_q     <= LW'(tail_q) + 1'b1;
            state_q <= ST_MOD_T;
          end else begin
            last_q  <= tail_q;
            state_q <= ST_WRITE;
          end
        end
        ST_MOD_T: begin
          if (m_q >= len_eff) begin
            m_q <= m_q - len_eff;
          end else begin
            tail_q <= IW'(m_q);
            last_q <= IW'(m_q);
            if (IW'(m_q) == head_q) begin
              m_q     <= LW'(head_q) + 1'b1;
              state_q <= ST_MOD_H;
            end else begin
              state_q <= ST_WRITE;
            end
          end
        end
        ST_MOD_H: begin
          if (m_q >= len_eff) begin
            m_q <= m_q - len_eff;
          end else begin
            head_q  <= IW'(m_q);
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (head_q == last_q) begin
            avg_q   <= rate_q;
            state_q <= ST_FINAL;
          end else begin
            state_q <= ST_WIN_RD;
          end
        end
        ST_WIN_RD: begin
          state_q <= (now_q > ring_rt) ? ST_WIN_WAIT : ST_FINAL;
        end
        ST_WIN_WAIT: begin
          if (div_rsp.done) begin
            avg_q   <= div_rsp.quot;
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          win_q   <= avg_q;
          state_q <= fin_q ? ST_FIN_WAIT : ST_PCT;
        end
        ST_FIN_WAIT: begin
          if (div_rsp.done) begin
            rate_q  <= div_rsp.quot;
            win_q   <= div_rsp.quot;
            state_q <= ST_PCT;
          end
        end
        ST_PCT: begin
          if (expected_q == '0) begin
            pct_q   <= (ramp > RampTop) ? '0 : ramp[PctW-1:0];
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_PCT_WAIT;
          end
        end
        ST_PCT_WAIT: begin
          if (div_rsp.done) begin
            pct_q   <= (div_rsp.quot > BytesW'(PctCap)) ? PctCap : PctW'(div_rsp.quot);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            o_cur_q <= rate_q;
            o_win_q <= win_q;
            o_pct_q <= pct_q;
            o_min_q <= min_q;
            o_max_q <= max_q;
            o_sum_q <= sum_q;
            o_sq_q  <= sq_q;
            o_cnt_q <= count_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  tmr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tmr_ring #(
    .HistoryDepth (HistoryDepth)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ring_ctl),
    .rd_addr_i  (ring_raddr),
    .wr_addr_i  (last_q),
    .wr_time_i  (now_q),
    .wr_bytes_i (tot_q),
    .rd_time_o  (ring_rt),
    .rd_bytes_o (ring_rb)
  );

  assign out_o.valid             = out_v_q;
  assign out_o.current_rate      = o_cur_q;
  assign out_o.window_rate       = o_win_q;
  assign out_o.percent_done      = o_pct_q;
  assign out_o.lowest_rate       = o_min_q;
  assign out_o.highest_rate      = o_max_q;
  assign out_o.rate_total        = o_sum_q;
  assign out_o.rate_square_total = o_sq_q;
  assign out_o.sample_count      = o_cnt_q;

  `ASSERT_RST(div_start_idle, div_req.start |-> !div_rsp.busy)
  `ASSERT_RST(out_no_overwrite, out_load |-> (!out_v_q || out_o.ready))
  `ASSERT_ALWAYS(pct_in_range, pct_q <= PctCap)
  `ASSERT_RST(count_monotonic, count_q >= $past(count_q))

endmodule

// ----- src/tmr_div.sv -----
// scaled iterative divider: floor(num * k / den), saturated to 48 bits
`timescale 1ns / 1ps
module tmr_div import tmr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned PW = 45;
  localparam int unsigned WW = 70;

  typedef enum logic [2:0] {D_IDLE, D_MLO, D_MHI, D_SUM, D_RUN} dstate_e;

  dstate_e           state_q;
  logic [NumW-1:0]   a_q;
  logic [KW-1:0]     k_q;
  logic [BytesW-1:0] d_q;
  logic [PW-1:0]     plo_q, phi_q;
  logic [WW-1:0]     num_q, quo_q;
  logic [BytesW:0]   rem_q;
  logic [6:0]        cnt_q;
  logic              done_q;
  logic [BytesW+1:0] trial;
  logic              fits;

  assign trial = {rem_q, num_q[WW-1]};
  assign fits  = trial >= {2'b00, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      a_q     <= '0;
      k_q     <= '0;
      d_q     <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= (state_q == D_RUN) && (cnt_q == 7'd0);
      case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.num;
            k_q     <= (req_i.mode == DIV_PCT) ? PctScale : UsecPerSec;
            d_q     <= req_i.den;
            state_q <= D_MLO;
          end
        end
        D_MLO: begin
          plo_q   <= PW'(a_q[24:0] * k_q);
          state_q <= D_MHI;
        end
        D_MHI: begin
          phi_q   <= PW'(a_q[NumW-1:25] * k_q);
          state_q <= D_SUM;
        end
        D_SUM: begin
          num_q   <= {phi_q, 25'd0} + WW'(plo_q);
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= 7'(WW - 1);
          state_q <= D_RUN;
        end
        D_RUN: begin
          rem_q <= fits ? (BytesW+1)'(trial - {2'b00, d_q}) : trial[BytesW:0];
          quo_q <= {quo_q[WW-2:0], fits};
          num_q <= {num_q[WW-2:0], 1'b0};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) begin
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (state_q != D_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = ((d_q == '0) || (|quo_q[WW-1:BytesW])) ? Max48 : quo_q[BytesW-1:0];

endmodule

// ----- src/tmr_ring.sv -----
// history ring memory of (time, bytes) samples with per-entry valid bits
`timescale 1ns / 1ps
module tmr_ring import tmr_pkg::*; #(
  parameter int unsigned HistoryDepth = HistoryDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ring_ctl_t                       ctl_i,
  input  logic [$clog2(HistoryDepth)-1:0] rd_addr_i,
  input  logic [$clog2(HistoryDepth)-1:0] wr_addr_i,
  input  logic [TimeW-1:0]                wr_time_i,
  input  logic [BytesW-1:0]               wr_bytes_i,
  output logic [TimeW-1:0]                rd_time_o,
  output logic [BytesW-1:0]               rd_bytes_o
);

  logic [TimeW-1:0]        mem_time [HistoryDepth];
  logic [BytesW-1:0]       mem_bytes [HistoryDepth];
  logic [HistoryDepth-1:0] valid_q;
  logic [TimeW-1:0]        rt_q;
  logic [BytesW-1:0]       rb_q;
  logic                    rv_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_time[wr_addr_i]  <= wr_time_i;
      mem_bytes[wr_addr_i] <= wr_bytes_i;
    end
    if (ctl_i.rd) begin
      rt_q <= mem_time[rd_addr_i];
      rb_q <= mem_bytes[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rv_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_time_o  = rv_q ? rt_q : '0;
  assign rd_bytes_o = rv_q ? rb_q : '0;

endmodule
